>>> hw/rtl/vna_pkg.sv
`default_nettype none
package vna_pkg;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 34;
    localparam int FACE_W = 35;
    localparam int Q15_W  = 16;

    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;

    localparam logic [1:0] WGT_AREA = 2'd0;
    localparam logic [1:0] WGT_UNIT = 2'd1;
    localparam logic [1:0] WGT_FLAT = 2'd2;

    typedef struct packed {
        logic                    done;
        logic                    zero;
        logic signed [Q15_W-1:0] x;
        logic signed [Q15_W-1:0] y;
        logic signed [Q15_W-1:0] z;
    } norm_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/vna_ram.sv
`default_nettype none
module vna_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/vna_norm.sv
`default_nettype none
module vna_norm import vna_pkg::*; #(
    parameter int VW = 48
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [VW-1:0] vin_x,
    input  wire logic signed [VW-1:0] vin_y,
    input  wire logic signed [VW-1:0] vin_z,
    output norm_res_t                 res
);

    typedef enum logic [4:0] {
        N_IDLE  = 5'b00001,
        N_SHIFT = 5'b00010,
        N_SQ    = 5'b00100,
        N_ROOT  = 5'b01000,
        N_DIV   = 5'b10000
    } nstate_t;

    nstate_t state_reg, state_next;

    logic [VW-1:0]    m_reg [3];
    logic [2:0]       neg_reg;
    logic [1:0]       cnt_reg;
    logic [59:0]      sq_reg;
    logic [61:0]      s_reg;
    logic [61:0]      r_reg;
    logic [61:0]      bit_reg;
    logic [48:0]      rem_reg;
    logic [4:0]       step_reg;
    logic [16:0]      q_reg;
    logic             done_reg;
    logic             zero_reg;
    logic [Q15_W-1:0] n_reg [3];

    logic             any_hi;
    logic             all_lo;
    logic             all_zero;
    logic [61:0]      trial;
    logic [30:0]      len;
    logic [48:0]      den_sh;
    logic             ge;
    logic [16:0]      q_new;
    logic [Q15_W-1:0] q_out;
    logic [1:0]       jn;

    always_comb begin
        any_hi   = 1'b0;
        all_lo   = 1'b1;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            any_hi   = any_hi | (|m_reg[i][VW-1:30]);
            all_lo   = all_lo & ~(|m_reg[i][VW-1:29]);
            all_zero = all_zero & ~(|m_reg[i]);
        end
    end

    assign trial  = r_reg + bit_reg;
    assign len    = r_reg[30:0];
    assign den_sh = 49'({len, 1'b0}) << step_reg;
    assign ge     = rem_reg >= den_sh;
    assign q_new  = {q_reg[15:0], ge};
    assign jn     = (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;

    always_comb begin
        if (neg_reg[cnt_reg]) begin
            q_out = Q15_W'(-q_new);
        end else if (q_new[16] || q_new[15]) begin
            q_out = 16'h7fff;
        end else begin
            q_out = q_new[15:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE:  if (start) state_next = N_SHIFT;
            N_SHIFT: begin
                if (all_zero) begin
                    state_next = N_IDLE;
                end else if (!any_hi && !all_lo) begin
                    state_next = N_SQ;
                end
            end
            N_SQ:    if (cnt_reg == 2'd3) state_next = N_ROOT;
            N_ROOT:  if (bit_reg[0]) state_next = N_DIV;
            N_DIV:   if (step_reg == 5'd0 && cnt_reg == 2'd2) state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == N_SHIFT && all_zero) ||
                         (state_reg == N_DIV && step_reg == 5'd0 && cnt_reg == 2'd2);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                m_reg[0]   <= vin_x[VW-1] ? VW'(-vin_x) : vin_x;
                m_reg[1]   <= vin_y[VW-1] ? VW'(-vin_y) : vin_y;
                m_reg[2]   <= vin_z[VW-1] ? VW'(-vin_z) : vin_z;
                neg_reg    <= {vin_z[VW-1], vin_y[VW-1], vin_x[VW-1]};
                cnt_reg    <= 2'd0;
                s_reg      <= '0;
            end
            N_SHIFT: begin
                if (all_zero) begin
                    zero_reg <= 1'b1;
                    n_reg[0] <= '0;
                    n_reg[1] <= '0;
                    n_reg[2] <= '0;
                end else if (any_hi) begin
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                end else if (all_lo) begin
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                end
            end
            N_SQ: begin
                if (cnt_reg != 2'd3) begin
                    sq_reg <= m_reg[cnt_reg][29:0] * m_reg[cnt_reg][29:0];
                end
                if (cnt_reg != 2'd0) begin
                    s_reg <= s_reg + 62'(sq_reg);
                end
                cnt_reg <= cnt_reg + 2'd1;
                r_reg   <= '0;
                bit_reg <= 62'd1 << 60;
            end
            N_ROOT: begin
                if (s_reg >= trial) begin
                    s_reg <= s_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                cnt_reg  <= 2'd0;
                step_reg <= 5'd16;
                q_reg    <= '0;
                rem_reg  <= 49'({m_reg[0][29:0], 16'h0000}) +
                            49'((bit_reg[0] && s_reg >= trial) ?
                                31'((r_reg >> 1) + bit_reg) : 31'(r_reg >> 1));
            end
            N_DIV: begin
                if (step_reg == 5'd0) begin
                    n_reg[cnt_reg] <= q_out;
                    zero_reg       <= 1'b0;
                    cnt_reg        <= jn;
                    step_reg       <= 5'd16;
                    q_reg          <= '0;
                    rem_reg        <= 49'({m_reg[jn][29:0], 16'h0000}) + 49'(len);
                end else begin
                    if (ge) begin
                        rem_reg <= rem_reg - den_sh;
                    end
                    q_reg    <= q_new;
                    step_reg <= step_reg - 5'd1;
                end
            end
            default: begin
                cnt_reg <= 2'd0;
            end
        endcase
    end

    assign res.done = done_reg;
    assign res.zero = zero_reg;
    assign res.x    = n_reg[0];
    assign res.y    = n_reg[1];
    assign res.z    = n_reg[2];

endmodule
`default_nettype wire

>>> hw/rtl/vertex_normal_accumulator.sv
`default_nettype none
// Vertex normal accumulator.
// s_ channel: one word per command; s_tuser holds the mode (load, triangle, read).
// A load stores a position and clears that vertex's sum; a triangle reads three
// positions, forms cross(c-b, a-b) and folds it into the sums of a, b and c.
// A read returns the normalized sum of one vertex on the m_ channel with
// m_tuser set when that sum is zero (normal then zero).
// cfg_ channel writes the weighting register (area, unit, flat); write it idle.
// In unit mode a triangle folds the unit normal of its face instead, and in flat
// mode that unit normal replaces the sums of its corners; such a triangle and a
// read of an in-range vertex pass through the normalizer.
// The normalizer shifts the vector into range, squares and sums its components,
// takes the square root and divides each component by that length, then signals
// done (a zero vector ends at the shift step); one word is in flight at a time,
// bounded by that unit and the accumulator read-modify-write.
// After reset the block sweeps the accumulator memory to zero, one entry per
// cycle, with s_tready low; cfg writes are taken throughout.
// A finished result sits in an output register; while the receiver stalls the
// block still accepts loads and triangles and holds only at the next read.
module vertex_normal_accumulator import vna_pkg::*; #(
    parameter int VERTICES   = 1024,
    parameter int ACCUM_BITS = 48
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vertex_index, pos_x_in, pos_y_in, pos_z_in, corner_a, corner_b, corner_c
    input  wire logic [87:0] s_tdata,
    // mode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_index, normal_x, normal_y, normal_z, zero padding
    output logic [63:0]      m_tdata,
    // zero_length
    output logic [0:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data
);

    localparam int AW = $clog2(VERTICES);
    localparam int CW = (AW > IDX_W) ? AW : IDX_W;
    localparam int AB = ACCUM_BITS;

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_TRA    = 13'b0000000000100,
        S_TRB    = 13'b0000000001000,
        S_TRC    = 13'b0000000010000,
        S_DIFF   = 13'b0000000100000,
        S_MUL    = 13'b0000001000000,
        S_NSTART = 13'b0000010000000,
        S_NWAIT  = 13'b0000100000000,
        S_CRD    = 13'b0001000000000,
        S_CWR    = 13'b0010000000000,
        S_RRD    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    function automatic logic in_rng(input logic [IDX_W-1:0] i);
        logic [CW:0] e;
        e = (CW+1)'(i);
        return e < (CW+1)'(VERTICES);
    endfunction

    state_t state_reg, state_next;

    logic [1:0]       weighting_reg;
    logic [AW:0]      clr_reg;
    logic [IDX_W-1:0] vi_reg;
    logic [IDX_W-1:0] corner_reg [3];
    logic [1:0]       k_reg;
    logic             is_read_reg;
    logic             oor_reg;
    logic signed [POS_W-1:0]  pa_reg [3];
    logic signed [POS_W-1:0]  pb_reg [3];
    logic signed [DIFF_W-1:0] cb_reg [3];
    logic signed [DIFF_W-1:0] ab_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [FACE_W-1:0] f_reg [3];
    logic [2:0]       mcnt_reg;
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic [Q15_W-1:0] m_n_reg [3];
    logic             m_zero_reg;

    logic [1:0]       in_mode;
    logic [IDX_W-1:0] in_vi;
    logic [IDX_W-1:0] in_c [3];
    logic             accept;
    logic             unit_mode;

    logic             pos_we;
    logic [AW-1:0]    pos_raddr;
    logic [3*POS_W-1:0] pos_rdata;
    logic signed [POS_W-1:0] pr [3];
    logic             sum_we;
    logic [AW-1:0]    sum_waddr;
    logic [3*AB-1:0]  sum_wdata;
    logic [AW-1:0]    sum_raddr;
    logic [3*AB-1:0]  sum_rdata;
    logic signed [AB-1:0] sr [3];
    logic signed [AB-1:0] addv [3];
    logic signed [AB-1:0] newv [3];
    logic signed [AB:0]   wide [3];

    logic signed [DIFF_W-1:0] op_a, op_b;
    logic signed [AB-1:0] nv [3];
    norm_res_t        nres;

    assign in_mode   = s_tuser;
    assign in_vi     = s_tdata[9:0];
    assign in_c[0]   = s_tdata[67:58];
    assign in_c[1]   = s_tdata[77:68];
    assign in_c[2]   = s_tdata[87:78];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign unit_mode = (weighting_reg == WGT_UNIT) || (weighting_reg == WGT_FLAT);

    assign pos_we = accept && in_mode == MODE_LOAD && in_rng(in_vi);

    always_comb begin
        case (state_reg)
            S_TRB:   pos_raddr = AW'(corner_reg[1]);
            S_TRC:   pos_raddr = AW'(corner_reg[2]);
            default: pos_raddr = AW'(corner_reg[0]);
        endcase
    end

    vna_ram #(.WIDTH(3*POS_W), .DEPTH(VERTICES)) u_pos_ram (
        .clk  (aclk),
        .we   (pos_we),
        .waddr(AW'(in_vi)),
        .wdata(s_tdata[57:10]),
        .raddr(pos_raddr),
        .rdata(pos_rdata)
    );

    assign pr[0] = pos_rdata[15:0];
    assign pr[1] = pos_rdata[31:16];
    assign pr[2] = pos_rdata[47:32];

    assign sum_raddr = (state_reg == S_CRD || state_reg == S_CWR) ?
                       AW'(corner_reg[k_reg]) : AW'(vi_reg);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sr[i]   = sum_rdata[i*AB +: AB];
            addv[i] = unit_mode ? AB'(nv[i]) : AB'(f_reg[i]);
            wide[i] = (AB+1)'(sr[i]) + (AB+1)'(addv[i]);
            if (weighting_reg == WGT_FLAT) begin
                newv[i] = addv[i];
            end else if (wide[i][AB] != wide[i][AB-1]) begin
                newv[i] = wide[i][AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
            end else begin
                newv[i] = wide[i][AB-1:0];
            end
        end
    end

    assign nv[0] = AB'(nres.x);
    assign nv[1] = AB'(nres.y);
    assign nv[2] = AB'(nres.z);

    always_comb begin
        if (state_reg == S_CLEAR) begin
            sum_we    = 1'b1;
            sum_waddr = clr_reg[AW-1:0];
            sum_wdata = '0;
        end else if (state_reg == S_CWR) begin
            sum_we    = 1'b1;
            sum_waddr = AW'(corner_reg[k_reg]);
            sum_wdata = {newv[2], newv[1], newv[0]};
        end else begin
            sum_we    = pos_we;
            sum_waddr = AW'(in_vi);
            sum_wdata = '0;
        end
    end

    vna_ram #(.WIDTH(3*AB), .DEPTH(VERTICES)) u_sum_ram (
        .clk  (aclk),
        .we   (sum_we),
        .waddr(sum_waddr),
        .wdata(sum_wdata),
        .raddr(sum_raddr),
        .rdata(sum_rdata)
    );

    vna_norm #(.VW(AB)) u_norm (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (state_reg == S_NSTART),
        .vin_x  (is_read_reg ? sr[0] : AB'(f_reg[0])),
        .vin_y  (is_read_reg ? sr[1] : AB'(f_reg[1])),
        .vin_z  (is_read_reg ? sr[2] : AB'(f_reg[2])),
        .res    (nres)
    );

    always_comb begin
        case (mcnt_reg)
            3'd0:    begin op_a = cb_reg[1]; op_b = ab_reg[2]; end
            3'd1:    begin op_a = cb_reg[2]; op_b = ab_reg[1]; end
            3'd2:    begin op_a = cb_reg[2]; op_b = ab_reg[0]; end
            3'd3:    begin op_a = cb_reg[0]; op_b = ab_reg[2]; end
            3'd4:    begin op_a = cb_reg[0]; op_b = ab_reg[1]; end
            default: begin op_a = cb_reg[1]; op_b = ab_reg[0]; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (AW+1)'(VERTICES - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (in_mode == MODE_TRIANGLE) begin
                        if (in_rng(in_c[0]) && in_rng(in_c[1]) && in_rng(in_c[2])) begin
                            state_next = S_TRA;
                        end
                    end else if (in_mode == MODE_READ) begin
                        state_next = in_rng(in_vi) ? S_RRD : S_OUT;
                    end
                end
            end
            S_TRA:    state_next = S_TRB;
            S_TRB:    state_next = S_TRC;
            S_TRC:    state_next = S_DIFF;
            S_DIFF:   state_next = S_MUL;
            S_MUL:    if (mcnt_reg == 3'd6) state_next = unit_mode ? S_NSTART : S_CRD;
            S_NSTART: state_next = S_NWAIT;
            S_NWAIT:  if (nres.done) state_next = is_read_reg ? S_OUT : S_CRD;
            S_CRD:    state_next = S_CWR;
            S_CWR:    state_next = (k_reg == 2'd2) ? S_IDLE : S_CRD;
            S_RRD:    state_next = S_NSTART;
            S_OUT:    if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            weighting_reg <= WGT_AREA;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + (AW+1)'(1);
            end
            if (cfg_valid) begin
                weighting_reg <= cfg_data;
            end
            if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vi_reg      <= in_vi;
            corner_reg  <= in_c;
            is_read_reg <= (in_mode == MODE_READ);
            oor_reg     <= !in_rng(in_vi);
        end
        if (state_reg == S_TRB) pa_reg <= pr;
        if (state_reg == S_TRC) pb_reg <= pr;
        if (state_reg == S_DIFF) begin
            for (int i = 0; i < 3; i++) begin
                cb_reg[i] <= DIFF_W'(pr[i]) - DIFF_W'(pb_reg[i]);
                ab_reg[i] <= DIFF_W'(pa_reg[i]) - DIFF_W'(pb_reg[i]);
            end
            mcnt_reg <= 3'd0;
        end
        if (state_reg == S_MUL) begin
            if (mcnt_reg != 3'd6) begin
                prod_reg <= op_a * op_b;
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            if (mcnt_reg != 3'd0) begin
                if (mcnt_reg[0]) begin
                    f_reg[2'((mcnt_reg - 3'd1) >> 1)] <= FACE_W'(prod_reg);
                end else begin
                    f_reg[2'((mcnt_reg - 3'd1) >> 1)] <=
                        f_reg[2'((mcnt_reg - 3'd1) >> 1)] - FACE_W'(prod_reg);
                end
            end
            k_reg <= 2'd0;
        end
        if (state_reg == S_CWR) begin
            k_reg <= k_reg + 2'd1;
        end
        if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
            m_idx_reg  <= vi_reg;
            m_zero_reg <= oor_reg ? 1'b1 : nres.zero;
            m_n_reg[0] <= oor_reg ? '0 : nres.x;
            m_n_reg[1] <= oor_reg ? '0 : nres.y;
            m_n_reg[2] <= oor_reg ? '0 : nres.z;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_n_reg[2], m_n_reg[1], m_n_reg[0], m_idx_reg};
    assign m_tuser  = m_zero_reg;

endmodule
`default_nettype wire

>>> tb/vertex_normal_accumulator_test.sv
`timescale 1ns / 1ps

module vertex_normal_accumulator_test import vna_pkg::*;;

    localparam int NVERT = 1024;
    localparam longint ACC_MAX = (longint'(1) <<< 47) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE = 400;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] WGT_SPARE   = 2'd3;

    typedef struct {
        logic [9:0]         idx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               zl;
    } normal_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;

    vertex_normal_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    shortint     pos_x[NVERT];
    shortint     pos_y[NVERT];
    shortint     pos_z[NVERT];
    longint      acc_x[NVERT];
    longint      acc_y[NVERT];
    longint      acc_z[NVERT];
    bit          loaded[NVERT];
    int          loaded_list[$];
    logic [1:0]  weight_mode;
    normal_word_t pending_normals[$];

    int failures;
    int burst_left;
    int hold_off;
    int stall_left;
    int rx_style;
    int idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit unit_normal(input longint vx, input longint vy, input longint vz,
                                       output logic signed [15:0] nx,
                                       output logic signed [15:0] ny,
                                       output logic signed [15:0] nz);
        longint v[3];
        longint unsigned m[3];
        longint unsigned big, s, len, r, b, q;
        logic signed [15:0] n[3];
        v[0] = vx; v[1] = vy; v[2] = vz;
        for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
        big = m[0];
        if (m[1] > big) big = m[1];
        if (m[2] > big) big = m[2];
        nx = 0; ny = 0; nz = 0;
        if (big == 0) return 1'b0;
        while (big >= (64'd1 << 30)) begin
            big >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (big < (64'd1 << 29)) begin
            big <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        len = r;
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 65536 + len) / (2 * len);
            if (v[i] < 0) n[i] = -q[15:0];
            else n[i] = (q > 32767) ? 16'sd32767 : q[15:0];
        end
        nx = n[0]; ny = n[1]; nz = n[2];
        return 1'b1;
    endfunction

    function automatic longint sat_sum(input longint a, input longint d);
        if (d > 0 && a > ACC_MAX - d) return ACC_MAX;
        if (d < 0 && a < ACC_MIN - d) return ACC_MIN;
        return a + d;
    endfunction

    task automatic fold_face(input int a, input int b, input int c);
        longint cb[3], ab[3], f[3], add[3];
        logic signed [15:0] ux, uy, uz;
        int corner[3];
        cb[0] = longint'(pos_x[c]) - pos_x[b];
        cb[1] = longint'(pos_y[c]) - pos_y[b];
        cb[2] = longint'(pos_z[c]) - pos_z[b];
        ab[0] = longint'(pos_x[a]) - pos_x[b];
        ab[1] = longint'(pos_y[a]) - pos_y[b];
        ab[2] = longint'(pos_z[a]) - pos_z[b];
        f[0] = cb[1] * ab[2] - cb[2] * ab[1];
        f[1] = cb[2] * ab[0] - cb[0] * ab[2];
        f[2] = cb[0] * ab[1] - cb[1] * ab[0];
        corner[0] = a; corner[1] = b; corner[2] = c;
        if (weight_mode == WGT_UNIT || weight_mode == WGT_FLAT) begin
            void'(unit_normal(f[0], f[1], f[2], ux, uy, uz));
            add[0] = ux; add[1] = uy; add[2] = uz;
        end else begin
            add = f;
        end
        for (int k = 0; k < 3; k++) begin
            if (weight_mode == WGT_FLAT) begin
                acc_x[corner[k]] = add[0];
                acc_y[corner[k]] = add[1];
                acc_z[corner[k]] = add[2];
            end else begin
                acc_x[corner[k]] = sat_sum(acc_x[corner[k]], add[0]);
                acc_y[corner[k]] = sat_sum(acc_y[corner[k]], add[1]);
                acc_z[corner[k]] = sat_sum(acc_z[corner[k]], add[2]);
            end
        end
    endtask

    task automatic apply_command(input logic [1:0] mode, input logic [87:0] d);
        normal_word_t w;
        int vi;
        vi = d[9:0];
        if (mode == MODE_LOAD) begin
            pos_x[vi] = d[25:10];
            pos_y[vi] = d[41:26];
            pos_z[vi] = d[57:42];
            acc_x[vi] = 0; acc_y[vi] = 0; acc_z[vi] = 0;
            if (!loaded[vi]) begin
                loaded[vi] = 1'b1;
                loaded_list.insert(loaded_list.size(), vi);
            end
        end else if (mode == MODE_TRIANGLE) begin
            fold_face(d[67:58], d[77:68], d[87:78]);
        end else if (mode == MODE_READ) begin
            w.idx = vi;
            w.zl = !unit_normal(acc_x[vi], acc_y[vi], acc_z[vi], w.nx, w.ny, w.nz);
            pending_normals.insert(pending_normals.size(), w);
        end
    endtask

    task automatic send_word(input logic [1:0] mode, input logic [9:0] vi,
                             input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] pz, input logic [9:0] a,
                             input logic [9:0] b, input logic [9:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {c, b, a, pz, py, px, vi};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_command(mode, {c, b, a, pz, py, px, vi});
    endtask

    function automatic logic [15:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return $urandom_range(0, 1) ? 16'(-$urandom_range(0, 600)) : 16'($urandom_range(0, 600));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_loaded();
        return 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endfunction

    task automatic send_load(input logic [9:0] vi, input logic [15:0] px,
                             input logic [15:0] py, input logic [15:0] pz);
        send_word(MODE_LOAD, vi, px, py, pz, 10'($urandom), 10'($urandom), 10'($urandom));
    endtask

    task automatic send_face(input logic [9:0] a, input logic [9:0] b, input logic [9:0] c);
        send_word(MODE_TRIANGLE, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  a, b, c);
    endtask

    task automatic send_read(input logic [9:0] vi);
        send_word(MODE_READ, vi, 16'($urandom), 16'($urandom), 16'($urandom),
                  10'($urandom), 10'($urandom), 10'($urandom));
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_normals.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_weighting(input logic [1:0] w);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        weight_mode = w;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        logic [1:0] w;
        send_read(10'd0);
        send_load(10'd0, 16'h8000, 16'h8000, 16'h8000);
        send_load(10'd1023, 16'h7fff, 16'h8000, 16'h7fff);
        send_load(10'd341, 16'h8000, 16'h7fff, 16'h8000);
        send_load(10'd682, 16'h0100, 16'h0000, 16'hff00);
        send_read(10'd1023);
        for (int k = 0; k < 4; k++) begin
            w = 2'(k);
            write_weighting(w);
            send_face(10'd341, 10'd0, 10'd1023);
            send_face(10'd682, 10'd682, 10'd0);
            send_face(10'd0, 10'd1023, 10'd0);
            send_word(MODE_UNUSED, 10'd341, 16'hffff, 16'hffff, 16'hffff,
                      10'h3ff, 10'h3ff, 10'h3ff);
            send_read(10'd0);
            send_read(10'd682);
        end
        send_read(10'd1023);
        send_read(10'd341);
    endtask

    task automatic test_saturation();
        write_weighting(WGT_AREA);
        send_load(10'd100, 16'h8000, 16'h7fff, 16'h8000);
        send_load(10'd101, 16'h8000, 16'h8000, 16'h8000);
        send_load(10'd102, 16'h7fff, 16'h8000, 16'h7fff);
        for (int k = 0; k < 30; k++) begin
            send_face(10'd100, 10'd101, 10'd102);
            if (k % 10 == 0) send_read(10'd100);
        end
        send_read(10'd100);
        send_read(10'd101);
        send_read(10'd102);
    endtask

    task automatic test_random_phase(input logic [1:0] w, input int count);
        int r;
        write_weighting(w);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 22) send_load(10'($urandom), rand_pos(), rand_pos(), rand_pos());
            else if (r < 65) send_face(pick_loaded(), pick_loaded(), pick_loaded());
            else if (r < 95) send_read(($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                                   : pick_loaded());
            else send_word(MODE_UNUSED, 10'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
        end
    endtask

    task automatic test_backpressure();
        write_weighting(WGT_UNIT);
        hold_off = 1500;
        for (int k = 0; k < 60; k++) begin
            if (k % 3 == 0) send_read(pick_loaded());
            else send_face(pick_loaded(), pick_loaded(), pick_loaded());
        end
    endtask

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 299) == 0) rx_style = $urandom_range(0, 2);
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 40);
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        normal_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_normals.size() == 0) begin
                $error("unexpected normal word: %h / %b", m_tdata, m_tuser);
                failures++;
            end else begin
                w = pending_normals.pop_front();
                if (m_tdata[9:0] !== w.idx) begin
                    $error("read_index expected %0d got %0d", w.idx, m_tdata[9:0]);
                    failures++;
                end
                if (m_tdata[25:10] !== w.nx) begin
                    $error("normal_x expected %0d got %0d", w.nx, $signed(m_tdata[25:10]));
                    failures++;
                end
                if (m_tdata[41:26] !== w.ny) begin
                    $error("normal_y expected %0d got %0d", w.ny, $signed(m_tdata[41:26]));
                    failures++;
                end
                if (m_tdata[57:42] !== w.nz) begin
                    $error("normal_z expected %0d got %0d", w.nz, $signed(m_tdata[57:42]));
                    failures++;
                end
                if (m_tuser[0] !== w.zl) begin
                    $error("zero_length expected %0d got %0d", w.zl, m_tuser[0]);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready)
                         || (cfg_valid && cfg_ready))) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[vertex_normal_accumulator] ERROR");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin
        failures = 0;
        burst_left = 0;
        hold_off = 0;
        stall_left = 0;
        rx_style = 0;
        idle_cycles = 0;
        weight_mode = WGT_AREA;
        for (int i = 0; i < NVERT; i++) begin
            pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
            acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
            loaded[i] = 1'b0;
        end
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_phase(WGT_AREA, 300);
        test_random_phase(WGT_UNIT, 250);
        test_random_phase(WGT_FLAT, 250);
        test_random_phase(WGT_SPARE, 150);
        test_backpressure();
        test_random_phase(WGT_UNIT, 150);
        test_random_phase(WGT_AREA, 150);
        test_saturation();

        drain_and_settle();
        if (failures == 0) begin
            $display("[vertex_normal_accumulator] OK");
        end else begin
            $display("[vertex_normal_accumulator] ERROR");
        end
        $finish;
    end

endmodule
